// File: hdl/net_pkg.sv
// Shared types, codes and character classes for the notation element tokenizer.
`default_nettype none
package net_pkg;

  localparam int unsigned FIELD_LEN_DEF = 12;

  typedef enum logic [3:0] {
    MODE_IDLE = 4'd0,
    MODE_PF   = 4'd1,
    MODE_ZW   = 4'd2,
    MODE_MW   = 4'd3,
    MODE_SW   = 4'd4,
    MODE_FW   = 4'd5,
    MODE_FC   = 4'd6,
    MODE_ORN  = 4'd7,
    MODE_AMP  = 4'd8,
    MODE_DONE = 4'd9
  } mode_t;

  typedef enum logic [2:0] {
    ACT_SKIP   = 3'd0,
    ACT_START  = 3'd1,
    ACT_CONT   = 3'd2,
    ACT_ERR    = 3'd3,
    ACT_BEYOND = 3'd4
  } act_t;

  typedef enum logic [3:0] {
    KIND_NONE   = 4'd0,
    KIND_PF     = 4'd1,
    KIND_Z      = 4'd2,
    KIND_MEZZO  = 4'd3,
    KIND_ARPEG  = 4'd4,
    KIND_FINGER = 4'd5,
    KIND_ORN    = 4'd6,
    KIND_SINGLE = 4'd7,
    KIND_AMP    = 4'd8
  } kind_t;

  // One result item
  typedef struct packed {
    logic [3:0] element_count;
    logic       amp_counted;
    kind_t      elem_kind;
    act_t       action;
  } net_res_t;

  function automatic logic is_alnum(input logic [7:0] c);
    return ((c >= "0") && (c <= "9")) || ((c >= "A") && (c <= "Z")) ||
           ((c >= "a") && (c <= "z"));
  endfunction

  function automatic logic is_single_mark(input logic [7:0] c);
    logic hit;
    hit = 1'b0;
    case (c) inside
      "-", "(", ")", "[", "]", "{", "}", "z", "x", "*", "!", "v", "n", "o",
      "O", "Q", "A", "V", ">", ".", "_", "=", "i", "'", "F", "E", "R", "^",
      "+": hit = 1'b1;
      default: hit = 1'b0;
    endcase
    return hit;
  endfunction

  function automatic logic is_ornament(input logic [7:0] c);
    logic hit;
    hit = 1'b0;
    case (c) inside
      "t", "r", "k", "w", "~", "c", "M", "j": hit = 1'b1;
      default: hit = 1'b0;
    endcase
    return hit;
  endfunction

endpackage
`default_nettype wire

// File: hdl/net_scan_core.sv
// Scan state registers and per-character classification logic.
`default_nettype none
module net_scan_core #(
  parameter int unsigned FIELD_LEN = net_pkg::FIELD_LEN_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              step_en,
  input  wire logic [7:0]        ch,
  input  wire logic              field_start,
  input  wire logic              field_end,
  output net_pkg::net_res_t      res
);

  localparam logic [4:0] FL = 5'(FIELD_LEN);
  localparam logic [3:0] COL_MAX = 4'hF;

  net_pkg::mode_t mode_r, mode_nxt;
  logic [3:0]     col_r, col_nxt;
  logic [3:0]     cnt_r, cnt_nxt;

  net_pkg::mode_t m0;
  logic [3:0]     col0, cnt0, cnt1, cnt2, cnt3;
  logic           beyond, last;
  logic           handled, amp_a, st_cnt;
  net_pkg::act_t  act_c, st_act, act_f;
  net_pkg::kind_t kind_c, st_kind, kind_f;
  net_pkg::mode_t next_c, st_next, pre_next;
  logic           amp_f;

  function automatic logic [3:0] sat_inc(input logic [3:0] v);
    return ({1'b0, v} < FL) ? v + 4'd1 : v;
  endfunction

  always_comb begin
    m0   = field_start ? net_pkg::MODE_IDLE : mode_r;
    col0 = field_start ? 4'd0 : col_r;
    cnt0 = field_start ? 4'd0 : cnt_r;

    beyond = (m0 == net_pkg::MODE_DONE) || ({1'b0, col0} >= FL);
    last   = field_end || (({1'b0, col0} + 5'd1) >= FL);

    // continuation of the element in progress
    handled = 1'b0;
    amp_a   = 1'b0;
    act_c   = net_pkg::ACT_CONT;
    kind_c  = net_pkg::KIND_NONE;
    next_c  = net_pkg::MODE_IDLE;
    unique case (m0)
      net_pkg::MODE_PF: begin
        if (ch == "p" || ch == "f") begin
          handled = 1'b1; kind_c = net_pkg::KIND_PF; next_c = net_pkg::MODE_PF;
        end
      end
      net_pkg::MODE_ZW: begin
        if (ch == "p") begin
          handled = 1'b1; kind_c = net_pkg::KIND_Z;
        end
      end
      net_pkg::MODE_MW: begin
        handled = 1'b1;
        kind_c  = net_pkg::KIND_MEZZO;
        act_c   = (ch == "p" || ch == "f") ? net_pkg::ACT_CONT : net_pkg::ACT_ERR;
      end
      net_pkg::MODE_SW: begin
        if (ch == "d") begin
          handled = 1'b1; kind_c = net_pkg::KIND_ARPEG;
        end
      end
      net_pkg::MODE_FW: begin
        if (ch == ":") begin
          handled = 1'b1; kind_c = net_pkg::KIND_FINGER; next_c = net_pkg::MODE_FC;
        end
      end
      net_pkg::MODE_FC: begin
        handled = 1'b1; kind_c = net_pkg::KIND_FINGER;
      end
      net_pkg::MODE_ORN: begin
        if (ch == "s" || ch == "f" || ch == "h" || ch == "u") begin
          handled = 1'b1; kind_c = net_pkg::KIND_ORN; next_c = net_pkg::MODE_ORN;
        end
      end
      net_pkg::MODE_AMP: begin
        if (net_pkg::is_alnum(ch)) begin
          handled = 1'b1; kind_c = net_pkg::KIND_AMP;
        end else begin
          amp_a = 1'b1;
        end
      end
      default: handled = 1'b0;
    endcase

    // fresh element start
    st_act  = net_pkg::ACT_START;
    st_kind = net_pkg::KIND_NONE;
    st_next = net_pkg::MODE_IDLE;
    st_cnt  = 1'b1;
    if (ch == " ") begin
      st_act = net_pkg::ACT_SKIP; st_cnt = 1'b0;
    end else if (ch == "p" || ch == "f") begin
      st_kind = net_pkg::KIND_PF; st_next = net_pkg::MODE_PF;
    end else if (ch == "Z") begin
      st_kind = net_pkg::KIND_Z; st_next = net_pkg::MODE_ZW;
    end else if (ch == "m") begin
      st_kind = net_pkg::KIND_MEZZO; st_next = net_pkg::MODE_MW;
    end else if (ch == "S") begin
      st_kind = net_pkg::KIND_ARPEG; st_next = net_pkg::MODE_SW;
    end else if (ch >= "1" && ch <= "5") begin
      st_kind = net_pkg::KIND_FINGER; st_next = net_pkg::MODE_FW;
    end else if (net_pkg::is_ornament(ch)) begin
      st_kind = net_pkg::KIND_ORN; st_next = net_pkg::MODE_ORN;
    end else if (net_pkg::is_single_mark(ch)) begin
      st_kind = net_pkg::KIND_SINGLE;
    end else if (ch == "&") begin
      // ampersand waits to see whether it swallows the next character
      st_kind = net_pkg::KIND_AMP; st_next = net_pkg::MODE_AMP; st_cnt = 1'b0;
    end else begin
      st_act = net_pkg::ACT_ERR; st_cnt = 1'b0;
    end

    cnt1     = amp_a ? sat_inc(cnt0) : cnt0;
    cnt2     = (!handled && st_cnt) ? sat_inc(cnt1) : cnt1;
    act_f    = handled ? act_c : st_act;
    kind_f   = handled ? kind_c : st_kind;
    pre_next = handled ? next_c : st_next;
    amp_f    = amp_a;
    cnt3     = cnt2;
    mode_nxt = pre_next;
    if (last) begin
      if (pre_next == net_pkg::MODE_AMP) begin
        amp_f = 1'b1;
        cnt3  = sat_inc(cnt2);
      end else if (pre_next == net_pkg::MODE_MW) begin
        act_f = net_pkg::ACT_ERR;
      end
      mode_nxt = net_pkg::MODE_DONE;
    end
    col_nxt = (col0 < COL_MAX) ? col0 + 4'd1 : col0;
    cnt_nxt = cnt3;

    if (beyond) begin
      res.action        = net_pkg::ACT_BEYOND;
      res.elem_kind     = net_pkg::KIND_NONE;
      res.amp_counted   = 1'b0;
      res.element_count = cnt0;
      mode_nxt          = m0;
      col_nxt           = col0;
      cnt_nxt           = cnt0;
    end else begin
      res.action        = act_f;
      res.elem_kind     = kind_f;
      res.amp_counted   = amp_f;
      res.element_count = cnt3;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= net_pkg::MODE_IDLE;
      col_r  <= 4'd0;
      cnt_r  <= 4'd0;
    end else if (step_en) begin
      mode_r <= mode_nxt;
      col_r  <= col_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    {1'b0, cnt_r} <= FL)
    else $error("element count above field length");

  a_end_done: assert property (@(posedge clk) disable iff (!rst_n)
    step_en && !beyond && last |=> mode_r == net_pkg::MODE_DONE)
    else $error("scan not done after last character");

  a_beyond_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    step_en && beyond |-> res.elem_kind == net_pkg::KIND_NONE && !res.amp_counted)
    else $error("beyond-field result carries element data");

  a_cont_kind: assert property (@(posedge clk) disable iff (!rst_n)
    step_en && res.action == net_pkg::ACT_CONT |-> res.elem_kind != net_pkg::KIND_NONE)
    else $error("continuation without element kind");

endmodule
`default_nettype wire

// File: hdl/notation_element_tokenizer_top.sv
// An accepted input request passes through the input register, then the result
// register, before the result is valid.
// Throughput: one character per cycle while the result is not stalled.
// A result stalled by out_tready holds the input register and drops in_tready.
// Reset (rst_n low, synchronous) empties both registers and returns the scan
// to idle with column and element count at zero.
`default_nettype none
module notation_element_tokenizer_top #(
  parameter int unsigned FIELD_LEN = net_pkg::FIELD_LEN_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] ch
  input  wire logic        in_tuser,   // field_start
  input  wire logic        in_tlast,   // field_end
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [15:0]      out_tdata   // [2:0] action, [6:3] elem_kind,
                                       // [7] amp_counted, [11:8] element_count
);

  logic             in_valid_r;
  logic [7:0]       in_ch_r;
  logic             in_fs_r, in_fe_r;
  logic             out_valid_r;
  net_pkg::net_res_t out_res_r, res;
  logic             advance, in_take;

  assign advance   = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || advance;
  assign in_take   = in_tvalid && in_tready;

  net_scan_core #(.FIELD_LEN(FIELD_LEN)) u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .step_en     (advance),
    .ch          (in_ch_r),
    .field_start (in_fs_r),
    .field_end   (in_fe_r),
    .res         (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_take) begin
        in_valid_r <= 1'b1;
      end else if (advance) begin
        in_valid_r <= 1'b0;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_ch_r <= in_tdata;
      in_fs_r <= in_tuser;
      in_fe_r <= in_tlast;
    end
    if (advance) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'd0, out_res_r.element_count, out_res_r.amp_counted,
                       out_res_r.elem_kind, out_res_r.action};

endmodule
`default_nettype wire

// File: tb/testbench.sv
// Self-checking stream testbench for the notation element tokenizer.
module testbench;

  localparam int FIELD_LEN   = net_pkg::FIELD_LEN_DEF;
  localparam int ITEM_TARGET = 850;
  localparam int QUIET_AFTER = 760;
  localparam int STALL_LIMIT = 1000;

  logic        clk;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata   = '0;
  logic        in_tuser   = 1'b0;
  logic        in_tlast   = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;

  notation_element_tokenizer_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Scan state mirror
  net_pkg::mode_t scan_mode   = net_pkg::MODE_IDLE;
  logic [3:0]     column      = '0;
  logic [3:0]     elem_total  = '0;

  net_pkg::net_res_t expected_tokens[$];
  int         errors      = 0;
  int         items_sent  = 0;
  bit         src_idle_on = 1'b1;
  bit         sink_idle_on = 1'b1;
  int         stall_left  = 0;

  typedef struct {
    logic [7:0]        ch;
    logic              fs;
    logic              fe;
    logic              typed;
    net_pkg::net_res_t res;
  } row_t;

  function automatic net_pkg::net_res_t token_res(net_pkg::act_t a, net_pkg::kind_t k,
                                                  logic amp, logic [3:0] n);
    net_pkg::net_res_t r;
    r.action        = a;
    r.elem_kind     = k;
    r.amp_counted   = amp;
    r.element_count = n;
    return r;
  endfunction

  function automatic logic in_set(logic [7:0] c, string s);
    for (int i = 0; i < s.len(); i++)
      if (c == s[i]) return 1'b1;
    return 1'b0;
  endfunction

  function automatic logic alnum_char(logic [7:0] c);
    return (c >= "0" && c <= "9") || (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
  endfunction

  function automatic logic [7:0] pick_from(string s);
    return s[$urandom_range(0, s.len() - 1)];
  endfunction

  function automatic void count_element();
    if (elem_total < FIELD_LEN) elem_total = elem_total + 1'b1;
  endfunction

  // Predicts the result for one character and advances the mirrored scan state.
  function automatic net_pkg::net_res_t tokenize_char(logic [7:0] c, logic fs, logic fe);
    net_pkg::act_t  act;
    net_pkg::kind_t kind;
    logic           amp;
    net_pkg::mode_t next;
    logic           taken;
    logic           last;
    act   = net_pkg::ACT_SKIP;
    kind  = net_pkg::KIND_NONE;
    amp   = 1'b0;
    next  = net_pkg::MODE_IDLE;
    taken = 1'b0;
    if (fs) begin
      scan_mode  = net_pkg::MODE_IDLE;
      column     = '0;
      elem_total = '0;
    end
    if (scan_mode == net_pkg::MODE_DONE || column >= FIELD_LEN)
      return token_res(net_pkg::ACT_BEYOND, net_pkg::KIND_NONE, 1'b0, elem_total);
    last = fe || (int'(column) + 1 >= FIELD_LEN);

    case (scan_mode)
      net_pkg::MODE_PF: if (c == "p" || c == "f") begin
        act = net_pkg::ACT_CONT; kind = net_pkg::KIND_PF; next = net_pkg::MODE_PF;
        taken = 1'b1;
      end
      net_pkg::MODE_ZW: if (c == "p") begin
        act = net_pkg::ACT_CONT; kind = net_pkg::KIND_Z; taken = 1'b1;
      end
      net_pkg::MODE_MW: begin
        act   = (c == "p" || c == "f") ? net_pkg::ACT_CONT : net_pkg::ACT_ERR;
        kind  = net_pkg::KIND_MEZZO;
        taken = 1'b1;
      end
      net_pkg::MODE_SW: if (c == "d") begin
        act = net_pkg::ACT_CONT; kind = net_pkg::KIND_ARPEG; taken = 1'b1;
      end
      net_pkg::MODE_FW: if (c == ":") begin
        act = net_pkg::ACT_CONT; kind = net_pkg::KIND_FINGER; next = net_pkg::MODE_FC;
        taken = 1'b1;
      end
      net_pkg::MODE_FC: begin
        act = net_pkg::ACT_CONT; kind = net_pkg::KIND_FINGER; taken = 1'b1;
      end
      net_pkg::MODE_ORN: if (in_set(c, "sfhu")) begin
        act = net_pkg::ACT_CONT; kind = net_pkg::KIND_ORN; next = net_pkg::MODE_ORN;
        taken = 1'b1;
      end
      net_pkg::MODE_AMP: if (alnum_char(c)) begin
        act = net_pkg::ACT_CONT; kind = net_pkg::KIND_AMP; taken = 1'b1;
      end else begin
        // ampersand stands alone; the character is then scanned fresh
        amp = 1'b1;
        count_element();
      end
      default: ;
    endcase

    if (!taken) begin
      act = net_pkg::ACT_START;
      if (c == " ") act = net_pkg::ACT_SKIP;
      else if (c == "p" || c == "f") begin
        kind = net_pkg::KIND_PF; next = net_pkg::MODE_PF;
      end else if (c == "Z") begin
        kind = net_pkg::KIND_Z; next = net_pkg::MODE_ZW;
      end else if (c == "m") begin
        kind = net_pkg::KIND_MEZZO; next = net_pkg::MODE_MW;
      end else if (c == "S") begin
        kind = net_pkg::KIND_ARPEG; next = net_pkg::MODE_SW;
      end else if (c >= "1" && c <= "5") begin
        kind = net_pkg::KIND_FINGER; next = net_pkg::MODE_FW;
      end else if (in_set(c, "trkw~cMj")) begin
        kind = net_pkg::KIND_ORN; next = net_pkg::MODE_ORN;
      end else if (in_set(c, "-()[]{}zx*!vnoOQAV>._=i'FER^+")) kind = net_pkg::KIND_SINGLE;
      else if (c == "&") begin
        kind = net_pkg::KIND_AMP; next = net_pkg::MODE_AMP;
      end else act = net_pkg::ACT_ERR;
      // a pending ampersand is not counted until its fate is known
      if (act == net_pkg::ACT_START && kind != net_pkg::KIND_AMP) count_element();
    end

    if (last) begin
      if (next == net_pkg::MODE_AMP) begin
        amp = 1'b1;
        count_element();
      end else if (next == net_pkg::MODE_MW) begin
        act = net_pkg::ACT_ERR;
      end
      next = net_pkg::MODE_DONE;
    end
    scan_mode = next;
    if (column < 4'd15) column = column + 1'b1;
    return token_res(act, kind, amp, elem_total);
  endfunction

  // Offers one character; predicts once the request is taken.
  task automatic send_char(logic [7:0] c, logic fs, logic fe, logic typed,
                           net_pkg::net_res_t want);
    net_pkg::net_res_t predicted;
    if (src_idle_on && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= c;
    in_tuser  <= fs;
    in_tlast  <= fe;
    @(posedge clk);
    while (in_tready !== 1'b1) @(posedge clk);
    predicted = tokenize_char(c, fs, fe);
    expected_tokens.insert(expected_tokens.size(), typed ? want : predicted);
    items_sent++;
  endtask

  // Mostly well-formed elements with random content, plus noise bytes.
  task automatic send_random_field();
    logic [7:0] chars[$];
    int         len;
    int         fe_at;
    len = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 15) : $urandom_range(1, 12);
    while (chars.size() < len) begin
      case ($urandom_range(0, 11))
        0: repeat ($urandom_range(1, 3)) chars.insert(chars.size(), pick_from("pf"));
        1: begin
          chars.insert(chars.size(), "Z");
          if ($urandom_range(0, 1)) chars.insert(chars.size(), "p");
        end
        2: begin
          chars.insert(chars.size(), "m");
          chars.insert(chars.size(),
                       ($urandom_range(0, 5) != 0) ? pick_from("pf") : pick_from("xZm &3"));
        end
        3: begin
          chars.insert(chars.size(), "S");
          if ($urandom_range(0, 1)) chars.insert(chars.size(), "d");
        end
        4: begin
          chars.insert(chars.size(), 8'("1" + $urandom_range(0, 4)));
          if ($urandom_range(0, 1)) begin
            chars.insert(chars.size(), ":");
            chars.insert(chars.size(), 8'($urandom_range(0, 255)));
          end
        end
        5: begin
          chars.insert(chars.size(), pick_from("trkw~cMj"));
          repeat ($urandom_range(0, 3)) chars.insert(chars.size(), pick_from("sfhu"));
        end
        6, 7: chars.insert(chars.size(), pick_from("-()[]{}zx*!vnoOQAV>._=i'FER^+"));
        8: begin
          chars.insert(chars.size(), "&");
          case ($urandom_range(0, 2))
            0: chars.insert(chars.size(), pick_from("0aZ9qMS"));
            1: chars.insert(chars.size(), pick_from(" -&:p("));
            default: ;
          endcase
        end
        9: chars.insert(chars.size(), " ");
        10: chars.insert(chars.size(), 8'($urandom_range(0, 255)));
        default: chars.insert(chars.size(), 8'($urandom_range(32, 126)));
      endcase
    end
    // field end usually on the last character; sometimes early, sometimes never
    fe_at = ($urandom_range(0, 3) != 0) ? len - 1 : $urandom_range(0, len + 2);
    for (int i = 0; i < len; i++)
      send_char(chars[i], (i == 0) && ($urandom_range(0, 15) != 0), i == fe_at, 1'b0, '0);
  endtask

  task automatic report(string field, int want, int got);
    $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
    errors++;
  endtask

  task automatic check_result(net_pkg::net_res_t got);
    net_pkg::net_res_t want;
    if (expected_tokens.size() == 0) begin
      $display("%0t: unexpected result, expected none, actual %h", $time, got);
      errors++;
    end else begin
      want = expected_tokens.pop_front();
      if (got.action !== want.action) report("action", want.action, got.action);
      if (got.elem_kind !== want.elem_kind) report("elem_kind", want.elem_kind, got.elem_kind);
      if (got.amp_counted !== want.amp_counted)
        report("amp_counted", want.amp_counted, got.amp_counted);
      if (got.element_count !== want.element_count)
        report("element_count", want.element_count, got.element_count);
    end
  endtask

  // Result side: check accepted requests, random backpressure bursts
  always @(posedge clk) begin
    if (rst_n && out_tvalid === 1'b1 && out_tready)
      check_result(net_pkg::net_res_t'(out_tdata[11:0]));
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_tready <= 1'b0;
    end else if (sink_idle_on && $urandom_range(0, 7) == 0) begin
      stall_left <= $urandom_range(0, 5);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // Watchdog: cycles in a row with no request taken on either side
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("testbench NOT OK");
    $finish;
  end

  row_t dir_rows [0:27];

  initial begin
    dir_rows = '{
      // first character after reset opens a field without field_start
      '{"p",   1'b0, 1'b0, 1'b1,
        token_res(net_pkg::ACT_START, net_pkg::KIND_PF, 1'b0, 4'd1)},
      '{"f",   1'b0, 1'b0, 1'b0, '0},
      '{8'hFF, 1'b1, 1'b0, 1'b1,
        token_res(net_pkg::ACT_ERR, net_pkg::KIND_NONE, 1'b0, 4'd0)},
      '{8'h00, 1'b0, 1'b0, 1'b1,
        token_res(net_pkg::ACT_ERR, net_pkg::KIND_NONE, 1'b0, 4'd0)},
      '{"m",   1'b0, 1'b0, 1'b0, '0},
      // mezzo without p/f
      '{"x",   1'b0, 1'b0, 1'b1,
        token_res(net_pkg::ACT_ERR, net_pkg::KIND_MEZZO, 1'b0, 4'd1)},
      '{"m",   1'b0, 1'b0, 1'b0, '0},
      '{"f",   1'b0, 1'b0, 1'b0, '0},
      '{"Z",   1'b0, 1'b0, 1'b0, '0},
      '{"p",   1'b0, 1'b0, 1'b0, '0},
      '{"S",   1'b0, 1'b0, 1'b0, '0},
      '{"d",   1'b0, 1'b0, 1'b0, '0},
      '{"3",   1'b0, 1'b0, 1'b0, '0},
      '{":",   1'b0, 1'b0, 1'b0, '0},
      // past the full field width
      '{"q",   1'b0, 1'b0, 1'b1,
        token_res(net_pkg::ACT_BEYOND, net_pkg::KIND_NONE, 1'b0, 4'd5)},
      '{"&",   1'b1, 1'b0, 1'b0, '0},
      '{"a",   1'b0, 1'b0, 1'b0, '0},
      '{"&",   1'b0, 1'b0, 1'b0, '0},
      '{" ",   1'b0, 1'b0, 1'b1,
        token_res(net_pkg::ACT_SKIP, net_pkg::KIND_NONE, 1'b1, 4'd1)},
      '{"t",   1'b0, 1'b0, 1'b0, '0},
      '{"s",   1'b0, 1'b0, 1'b0, '0},
      '{"(",   1'b0, 1'b0, 1'b0, '0},
      '{"2",   1'b0, 1'b0, 1'b0, '0},
      '{":",   1'b0, 1'b0, 1'b0, '0},
      '{"&",   1'b0, 1'b1, 1'b0, '0},
      // ampersand, then mezzo, as the only character of a field
      '{"&",   1'b1, 1'b1, 1'b1,
        token_res(net_pkg::ACT_START, net_pkg::KIND_AMP, 1'b1, 4'd1)},
      '{"m",   1'b1, 1'b1, 1'b1,
        token_res(net_pkg::ACT_ERR, net_pkg::KIND_MEZZO, 1'b0, 4'd1)},
      '{"~",   1'b1, 1'b0, 1'b0, '0}
    };

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i])
      send_char(dir_rows[i].ch, dir_rows[i].fs, dir_rows[i].fe, dir_rows[i].typed,
                dir_rows[i].res);

    while (items_sent < ITEM_TARGET) begin
      if (items_sent > QUIET_AFTER) begin
        src_idle_on  = 1'b0;
        sink_idle_on = 1'b0;
      end else begin
        src_idle_on  = ($urandom_range(0, 3) != 0);
        sink_idle_on = ($urandom_range(0, 3) != 0);
      end
      send_random_field();
    end
    in_tvalid <= 1'b0;

    while (expected_tokens.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (errors == 0)
      $display("testbench OK");
    else
      $display("testbench NOT OK");
    $finish;
  end

endmodule
